// File: sv/salv_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// salv_pkg
// Shared types and constants of the set-associative LRU victim lookup.
// ---------------------------------------------------------------------------
package salv_pkg;

  localparam int WAYS    = 4;
  localparam int SETS    = 64;
  localparam int NBLOCKS = WAYS * SETS;

  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int BLK_W = (NBLOCKS > 1) ? $clog2(NBLOCKS) : 1;

  localparam int ADDR_W   = 32;
  localparam int TAG_W    = 32;
  localparam int BNUM_W   = 8;
  localparam int LRU_W    = 2;
  localparam int OFS_W    = 4;
  localparam int IDX_W    = 3;
  localparam int SHIFT_W  = 5;
  localparam int CFG_IX_W = 1;
  localparam int CFG_D_W  = 4;

  localparam logic [LRU_W-1:0] FAR_RANK = LRU_W'(WAYS - 1);

  localparam logic [OFS_W-1:0] OFS_RESET = OFS_W'(4);
  localparam logic [IDX_W-1:0] IDX_RESET = IDX_W'(6);

  typedef enum logic [0:0] {
    REQ_LOOKUP = 1'b0,
    REQ_WRITE  = 1'b1
  } req_t;

  typedef enum logic [CFG_IX_W-1:0] {
    CFG_OFFSET_BITS = 1'b0,
    CFG_INDEX_BITS  = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    req_t               req_type;
    logic [ADDR_W-1:0]  address;
    logic [BNUM_W-1:0]  entry_block;
    logic               entry_valid;
    logic [TAG_W-1:0]   entry_tag;
    logic [LRU_W-1:0]   entry_lru;
  } in_word_t;

  typedef struct packed {
    logic [BNUM_W-1:0] block_number;
    logic              hit;
    logic [LRU_W-1:0]  lru_rank;
  } out_word_t;

  typedef struct packed {
    logic capture;
    logic write;
    logic issue;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic last_way;
    logic out_free;
  } dp_sts_t;

endpackage
`default_nettype wire

// File: sv/salv_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// salv_ctrl
// Sequencer: accepts words, walks the ways of a set, hands off the result.
// ---------------------------------------------------------------------------
module salv_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire salv_pkg::req_t    req_type,
  output logic                   in_ready,
  input  wire salv_pkg::dp_sts_t sts,
  output salv_pkg::dp_cmd_t      cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RESULT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (req_type == salv_pkg::REQ_WRITE) begin
            cmd.write = 1'b1;
          end else begin
            cmd.capture = 1'b1;
            state_nxt   = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
        if (sts.last_way) begin
          state_nxt = ST_DRAIN;
        end
      end
      // The last way read is compared in this cycle.
      ST_DRAIN: begin
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// File: sv/salv_dp.sv
`default_nettype none
// ---------------------------------------------------------------------------
// salv_dp
// Metadata memory, configuration registers, way compare and result register.
// ---------------------------------------------------------------------------
module salv_dp (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire salv_pkg::in_word_t                in_data,
  input  wire logic                              cfg_valid,
  input  wire logic [salv_pkg::CFG_IX_W-1:0]     cfg_index,
  input  wire logic [salv_pkg::CFG_D_W-1:0]      cfg_data,
  input  wire salv_pkg::dp_cmd_t                 cmd,
  output salv_pkg::dp_sts_t                      sts,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output salv_pkg::out_word_t                    out_data
);

  typedef struct packed {
    logic                         valid;
    logic [salv_pkg::TAG_W-1:0]   tag;
    logic [salv_pkg::LRU_W-1:0]   lru;
  } meta_t;

  meta_t mem [salv_pkg::NBLOCKS];

  logic [salv_pkg::NBLOCKS-1:0] written_r;

  logic [salv_pkg::OFS_W-1:0]   offset_r;
  logic [salv_pkg::IDX_W-1:0]   index_r;

  logic [salv_pkg::SET_W-1:0]   set_r;
  logic [salv_pkg::TAG_W-1:0]   tag_r;
  logic [salv_pkg::TAG_W-1:0]   mask_r;
  logic [salv_pkg::WAY_W-1:0]   way_r;

  meta_t                        rd_r;
  logic                         rd_written_r;
  logic                         cmp_en_r;
  logic [salv_pkg::WAY_W-1:0]   cmp_way_r;
  logic [salv_pkg::BLK_W-1:0]   cmp_blk_r;

  logic                         hit_r;
  logic [salv_pkg::BLK_W-1:0]   hit_blk_r;
  logic [salv_pkg::LRU_W-1:0]   hit_lru_r;
  logic                         vic_found_r;
  logic [salv_pkg::BLK_W-1:0]   vic_blk_r;

  logic                         out_valid_r;
  salv_pkg::out_word_t          out_word_r;

  logic [salv_pkg::SHIFT_W-1:0] shift;
  logic [salv_pkg::ADDR_W-1:0]  set_full;
  logic [salv_pkg::ADDR_W-1:0]  idx_mask;
  logic [salv_pkg::BLK_W-1:0]   rd_addr;
  logic [salv_pkg::BLK_W-1:0]   wr_addr;
  logic                         wr_ok;
  logic                         ent_valid;
  logic [salv_pkg::LRU_W-1:0]   ent_lru;
  logic                         hit_now;

  // Address split for the word being captured.
  always_comb begin
    shift    = salv_pkg::SHIFT_W'(offset_r) + salv_pkg::SHIFT_W'(index_r);
    idx_mask = ~({salv_pkg::ADDR_W{1'b1}} << index_r);
    set_full = (in_data.address >> offset_r) & idx_mask;
  end

  assign rd_addr = salv_pkg::BLK_W'(int'(set_r) * salv_pkg::WAYS + int'(way_r));
  assign wr_addr = salv_pkg::BLK_W'(in_data.entry_block);
  assign wr_ok   = (int'(in_data.entry_block) < salv_pkg::NBLOCKS);

  // A block never written reads as invalid with its reset rank, the way position.
  always_comb begin
    ent_valid = rd_written_r & rd_r.valid;
    ent_lru   = rd_written_r ? rd_r.lru : salv_pkg::LRU_W'(cmp_way_r);
    hit_now   = ent_valid && ((rd_r.tag & mask_r) == tag_r);
  end

  assign sts.last_way = (way_r == salv_pkg::WAY_W'(salv_pkg::WAYS - 1));
  assign sts.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.write && wr_ok) begin
      mem[wr_addr] <= '{valid: in_data.entry_valid,
                        tag:   in_data.entry_tag,
                        lru:   in_data.entry_lru};
    end
    if (cmd.issue) begin
      rd_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r   <= '0;
      offset_r    <= salv_pkg::OFS_RESET;
      index_r     <= salv_pkg::IDX_RESET;
      way_r       <= '0;
      cmp_en_r    <= 1'b0;
      hit_r       <= 1'b0;
      vic_found_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          salv_pkg::CFG_OFFSET_BITS: offset_r <= cfg_data[salv_pkg::OFS_W-1:0];
          salv_pkg::CFG_INDEX_BITS:  index_r  <= cfg_data[salv_pkg::IDX_W-1:0];
          default: ;
        endcase
      end

      if (cmd.write && wr_ok) begin
        written_r[wr_addr] <= 1'b1;
      end

      cmp_en_r <= cmd.issue;
      if (cmd.capture) begin
        way_r       <= '0;
        hit_r       <= 1'b0;
        vic_found_r <= 1'b0;
      end else if (cmd.issue) begin
        way_r <= way_r + 1'b1;
      end

      // Ways arrive in order, so only the first hit and the first far rank count.
      if (cmp_en_r) begin
        if (hit_now && !hit_r) begin
          hit_r <= 1'b1;
        end
        if (!vic_found_r && ent_lru == salv_pkg::FAR_RANK) begin
          vic_found_r <= 1'b1;
        end
      end

      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      // The set count is a power of two, so the wrap is a truncation.
      set_r     <= salv_pkg::SET_W'(set_full);
      tag_r     <= in_data.address >> shift;
      mask_r    <= {salv_pkg::TAG_W{1'b1}} >> shift;
      vic_blk_r <= '0;
    end else if (cmp_en_r && !vic_found_r && ent_lru == salv_pkg::FAR_RANK) begin
      vic_blk_r <= cmp_blk_r;
    end
    if (cmd.issue) begin
      rd_written_r <= written_r[rd_addr];
      cmp_way_r    <= way_r;
      cmp_blk_r    <= rd_addr;
    end
    if (cmp_en_r && hit_now && !hit_r) begin
      hit_blk_r <= cmp_blk_r;
      hit_lru_r <= ent_lru;
    end
    if (cmd.load_out) begin
      out_word_r.block_number <= salv_pkg::BNUM_W'(hit_r ? hit_blk_r : vic_blk_r);
      out_word_r.hit          <= hit_r;
      out_word_r.lru_rank     <= hit_r ? hit_lru_r : salv_pkg::FAR_RANK;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

endmodule
`default_nettype wire

// File: sv/set_assoc_lru_victim_lookup.sv
`default_nettype none
// ---------------------------------------------------------------------------
// set_assoc_lru_victim_lookup
// Set-associative cache metadata lookup with LRU victim choice.
// ---------------------------------------------------------------------------
//  Channel  Direction  Word                  Handshake
//  in_      input      salv_pkg::in_word_t   in_valid / in_ready
//  out_     output     salv_pkg::out_word_t  out_valid / out_ready
//  cfg_     input      cfg_index, cfg_data   cfg_valid / cfg_ready
//
// A metadata write is stored without leaving the idle state. A lookup reads one
// way per cycle from the metadata memory and passes the scan, drain and result
// states before the next word is taken. Reset is synchronous; afterwards all
// blocks read invalid with their way position as rank, with no clearing pass.
// The result register holds a finished result while the next word is taken;
// a lookup stalls only in its final cycle if that register is still full.
module set_assoc_lru_victim_lookup (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire salv_pkg::in_word_t            in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output salv_pkg::out_word_t                out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [salv_pkg::CFG_IX_W-1:0] cfg_index,
  input  wire logic [salv_pkg::CFG_D_W-1:0]  cfg_data
);

  salv_pkg::dp_cmd_t cmd;
  salv_pkg::dp_sts_t sts;

  assign cfg_ready = 1'b1;

  salv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .req_type (in_data.req_type),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  salv_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// File: test/set_assoc_lru_victim_lookup_tb.sv
// ---------------------------------------------------------------------------
// set_assoc_lru_victim_lookup_tb
// Drives metadata writes and address lookups into the cache victim lookup
// and checks every result word against a local model of the valid, tag and
// rank arrays. Directed cases cover hits, victim choice, tag masking and
// the register extremes. After one long output hold-off, random traffic
// runs under several settings, with bursty input and random output stalls.
// ---------------------------------------------------------------------------
module set_assoc_lru_victim_lookup_tb;
  import salv_pkg::*;

  localparam int SETTLE_CYCLES = 20;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int RUN_LIMIT     = 4000000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [CFG_IX_W-1:0] cfg_index = CFG_OFFSET_BITS;
  logic [CFG_D_W-1:0]  cfg_data = '0;

  // Local copy of the metadata arrays and the two registers.
  logic              meta_valid [NBLOCKS];
  logic [TAG_W-1:0]  meta_tag   [NBLOCKS];
  logic [LRU_W-1:0]  meta_lru   [NBLOCKS];
  logic [OFS_W-1:0]  ofs_cfg;
  logic [IDX_W-1:0]  idx_cfg;

  out_word_t expected_q[$];
  int        fail_count = 0;

  // Sets and tags that random traffic keeps returning to, so lookups hit.
  logic [6:0]  hot_set [4];
  logic [31:0] hot_tag [4];

  // Receiver behavior, counted down and toggled in its own process.
  int   hold_left = 0;
  logic rx_throttle = 1'b1;
  int   run_left = 0;
  logic run_ready = 1'b0;

  set_assoc_lru_victim_lookup dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #(RUN_LIMIT);
    $display("FAIL set_assoc_lru_victim_lookup");
    $finish;
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left = hold_left - 1;
    end else if (!rx_throttle) begin
      out_ready = 1'b1;
    end else begin
      if (run_left == 0) begin
        run_ready = ~run_ready;
        run_left = run_ready ? $urandom_range(1, 12) : $urandom_range(1, 6);
      end
      out_ready = run_ready;
      run_left = run_left - 1;
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("result word with none expected: block_number %0d hit %0d lru_rank %0d",
               out_data.block_number, out_data.hit, out_data.lru_rank);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        if (out_data.block_number !== want.block_number) begin
          $error("block_number: expected %0d, got %0d", want.block_number,
                 out_data.block_number);
          fail_count++;
        end
        if (out_data.hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, out_data.hit);
          fail_count++;
        end
        if (out_data.lru_rank !== want.lru_rank) begin
          $error("lru_rank: expected %0d, got %0d", want.lru_rank, out_data.lru_rank);
          fail_count++;
        end
      end
    end
  end

  function automatic out_word_t predict_lookup(logic [ADDR_W-1:0] addr);
    int          shift;
    int          set_no;
    int          blk;
    int          way;
    logic [31:0] tagv;
    logic [31:0] tmask;
    logic        have_victim;
    out_word_t   r;
    shift = ofs_cfg + idx_cfg;
    tagv = addr >> shift;
    tmask = 32'hFFFF_FFFF >> shift;
    // A set field wider than the array wraps around the real sets.
    set_no = ((addr >> ofs_cfg) & ((32'd1 << idx_cfg) - 32'd1)) % SETS;
    r.block_number = '0;
    r.hit = 1'b0;
    r.lru_rank = FAR_RANK;
    have_victim = 1'b0;
    for (way = 0; way < WAYS; way++) begin
      blk = set_no * WAYS + way;
      if (meta_valid[blk] && ((meta_tag[blk] & tmask) == tagv)) begin
        r.block_number = BNUM_W'(blk);
        r.hit = 1'b1;
        r.lru_rank = meta_lru[blk];
        return r;
      end
      if (!have_victim && meta_lru[blk] == FAR_RANK) begin
        r.block_number = BNUM_W'(blk);
        have_victim = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] make_addr(logic [31:0] tagv, logic [6:0] set_field);
    int          shift;
    logic [31:0] a;
    shift = ofs_cfg + idx_cfg;
    a = tagv << shift;
    a = a | ((32'(set_field) & ((32'd1 << idx_cfg) - 32'd1)) << ofs_cfg);
    a = a | ($urandom & ((32'd1 << ofs_cfg) - 32'd1));
    return a;
  endfunction

  function automatic logic [BNUM_W-1:0] block_of(logic [6:0] set_field, int way);
    int set_no;
    set_no = (32'(set_field) & ((32'd1 << idx_cfg) - 32'd1)) % SETS;
    return BNUM_W'(set_no * WAYS + way);
  endfunction

  function automatic in_word_t random_word();
    in_word_t    w;
    int          pick;
    logic [31:0] tmask;
    tmask = 32'hFFFF_FFFF >> (int'(ofs_cfg) + int'(idx_cfg));
    w.req_type = REQ_LOOKUP;
    w.address = $urandom;
    w.entry_block = BNUM_W'($urandom);
    w.entry_valid = 1'($urandom);
    w.entry_tag = $urandom;
    w.entry_lru = LRU_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      w.req_type = REQ_WRITE;
      w.entry_block = block_of(hot_set[$urandom_range(0, 3)], $urandom_range(0, WAYS - 1));
      w.entry_valid = ($urandom_range(0, 5) != 0);
      // Bits above the tag width must not matter to the compare.
      w.entry_tag = hot_tag[$urandom_range(0, 3)] ^ ($urandom & ~tmask);
    end else if (pick < 85) begin
      w.address = make_addr(hot_tag[$urandom_range(0, 3)], hot_set[$urandom_range(0, 3)]);
    end else begin
      w.req_type = req_t'($urandom_range(0, 1));
    end
    return w;
  endfunction

  task automatic refresh_pools();
    int k;
    for (k = 0; k < 4; k++) begin
      hot_set[k] = 7'($urandom);
      hot_tag[k] = $urandom;
    end
  endtask

  task automatic offer_word(in_word_t w);
    @(negedge clk);
    in_valid = 1'b1;
    in_data = w;
    do @(posedge clk); while (!in_ready);
    if (w.req_type == REQ_WRITE) begin
      meta_valid[w.entry_block] = w.entry_valid;
      meta_tag[w.entry_block] = w.entry_tag;
      meta_lru[w.entry_block] = w.entry_lru;
    end else begin
      expected_q.push_back(predict_lookup(w.address));
    end
  endtask

  task automatic do_write(logic [BNUM_W-1:0] blk, logic v, logic [TAG_W-1:0] tagv,
                          logic [LRU_W-1:0] rank);
    in_word_t w;
    w = random_word();
    w.req_type = REQ_WRITE;
    w.entry_block = blk;
    w.entry_valid = v;
    w.entry_tag = tagv;
    w.entry_lru = rank;
    offer_word(w);
  endtask

  task automatic do_lookup(logic [ADDR_W-1:0] addr);
    in_word_t w;
    w = random_word();
    w.req_type = REQ_LOOKUP;
    w.address = addr;
    offer_word(w);
  endtask

  // Drops valid and lets the block empty out, then lets a write still in
  // flight land.
  task automatic wait_idle();
    int n;
    @(negedge clk);
    in_valid = 1'b0;
    n = 0;
    while (expected_q.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t which, logic [CFG_D_W-1:0] val);
    wait_idle();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = which;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    if (which == CFG_OFFSET_BITS) begin
      ofs_cfg = val;
    end else begin
      idx_cfg = val[IDX_W-1:0];
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic test_reset_state();
    // Nothing is valid yet, so the victim is the last way of the set.
    do_lookup(32'h0000_0000);
    do_lookup(32'hFFFF_FFFF);
  endtask

  task automatic test_hit_and_victim();
    do_write(8'd20, 1'b1, 32'h0000_0ABC, 2'd1);
    do_write(8'd21, 1'b1, 32'h0000_0ABC, 2'd2);
    do_lookup(make_addr(32'h0000_0ABC, 7'd5));
    do_write(8'd22, 1'b1, 32'hFFFF_FFFF, 2'd3);
    do_lookup(make_addr(32'hFFFF_FFFF, 7'd5));
    // A matching tag in an invalid way is still a miss.
    do_write(8'd23, 1'b0, 32'h0000_0777, 2'd0);
    do_lookup(make_addr(32'h0000_0777, 7'd5));
    // With no way at the far rank the victim falls back to block zero.
    do_write(8'd22, 1'b1, 32'hFFFF_FFFF, 2'd0);
    do_lookup(make_addr(32'h0000_0123, 7'd5));
    do_write(8'd255, 1'b1, 32'h0000_0000, 2'd3);
    do_lookup(make_addr(32'h0000_0000, 7'd63));
  endtask

  task automatic test_config_extremes();
    write_reg(CFG_OFFSET_BITS, 4'd0);
    write_reg(CFG_INDEX_BITS, 4'd0);
    do_write(8'd1, 1'b1, 32'hFFFF_FFFF, 2'd0);
    do_lookup(32'hFFFF_FFFF);
    do_lookup(32'h0000_0000);
    // Bit 3 of the index write falls outside the register.
    write_reg(CFG_OFFSET_BITS, 4'd15);
    write_reg(CFG_INDEX_BITS, 4'hF);
    do_write(block_of(7'h45, 3), 1'b1, 32'h0000_0155, 2'd2);
    do_lookup(make_addr(32'h0000_0155, 7'h45));
    do_lookup(make_addr(32'h0000_0156, 7'h7F));
    write_reg(CFG_OFFSET_BITS, 4'd12);
    write_reg(CFG_INDEX_BITS, 4'd6);
    do_lookup(32'hFFFF_FFFF);
    do_lookup(32'h0000_0000);
  endtask

  task automatic test_back_pressure();
    int k;
    refresh_pools();
    rx_throttle = 1'b1;
    hold_left = 300;
    for (k = 0; k < 24; k++) begin
      do_lookup(make_addr(hot_tag[k % 4], hot_set[$urandom_range(0, 3)]));
    end
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int phase;
    int sent;
    int burst;
    int gap;
    for (phase = 0; phase < 5; phase++) begin
      write_reg(CFG_OFFSET_BITS, CFG_D_W'($urandom_range(0, 15)));
      write_reg(CFG_INDEX_BITS, CFG_D_W'($urandom_range(0, 15)));
      refresh_pools();
      // The first phase runs with neither side idling.
      rx_throttle = (phase != 0);
      sent = 0;
      while (sent < 170) begin
        burst = $urandom_range(1, 16);
        while (burst > 0 && sent < 170) begin
          offer_word(random_word());
          burst--;
          sent++;
        end
        gap = (phase == 0) ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
          @(negedge clk);
          in_valid = 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end
    end
  endtask

  initial begin
    int b;
    for (b = 0; b < NBLOCKS; b++) begin
      meta_valid[b] = 1'b0;
      meta_tag[b] = '0;
      meta_lru[b] = LRU_W'(b % WAYS);
    end
    ofs_cfg = OFS_RESET;
    idx_cfg = IDX_RESET;
    refresh_pools();
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_hit_and_victim();
    test_config_extremes();
    test_back_pressure();
    test_random_traffic();

    wait_idle();
    if (expected_q.size() != 0) begin
      $error("%0d result words never arrived", expected_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("PASS set_assoc_lru_victim_lookup");
    end else begin
      $display("FAIL set_assoc_lru_victim_lookup");
    end
    $finish;
  end

endmodule
